### rtl/core/memo_result_table_macros.svh
// Assertion macros for the memo result table checker.
`ifndef MEMO_RESULT_TABLE_MACROS_SVH
`define MEMO_RESULT_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define MRT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define MRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/mrt_pkg.sv
// Shared types, constants and helpers of the memo result table.
package mrt_pkg;

  localparam int ENTRIES     = 16;
  localparam int IDX_W       = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int COUNT_W     = $clog2(ENTRIES + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DATA_W      = 64;
  localparam int CFG_IDX_W   = 4;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_IDX_W-1:0]  REG_KEY_BYTES     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_VALUE_BYTES   = CFG_IDX_W'(1);
  localparam logic [CFG_DATA_W-1:0] KEY_BYTES_RESET   = CFG_DATA_W'(8);
  localparam logic [CFG_DATA_W-1:0] VALUE_BYTES_RESET = CFG_DATA_W'(8);

  typedef enum logic {
    MODE_LOOKUP = 1'b0,
    MODE_STORE  = 1'b1
  } mode_t;

  typedef enum logic {
    BK_IDLE,
    BK_MATCH
  } back_state_t;

  typedef struct packed {
    mode_t              mode;
    logic [DATA_W-1:0]  key;
    logic [DATA_W-1:0]  value;
    logic               store_en;
  } item_t;

  typedef struct packed {
    logic [DATA_W-1:0] kmask;
    logic [DATA_W-1:0] vmask;
  } masks_t;

  function automatic logic [DATA_W-1:0] byte_mask(logic [CFG_DATA_W-1:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int b = 0; b < DATA_W / 8; b++) begin
      if (CFG_DATA_W'(b) < n) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

### rtl/core/mrt_front.sv
// Front end: configuration registers and masking of incoming requests.
module mrt_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [mrt_pkg::DATA_W-1:0]      key,
  input  logic [mrt_pkg::DATA_W-1:0]      value,
  input  logic                            q_full,
  output logic                            push,
  output mrt_pkg::item_t                  push_item,
  output mrt_pkg::masks_t                 masks
);
  import mrt_pkg::*;

  logic [CFG_DATA_W-1:0] key_bytes;
  logic [CFG_DATA_W-1:0] value_bytes;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_bytes   <= KEY_BYTES_RESET;
      value_bytes <= VALUE_BYTES_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_KEY_BYTES) begin
        key_bytes <= cfg_data;
      end else if (cfg_index == REG_VALUE_BYTES) begin
        value_bytes <= cfg_data;
      end
    end
  end

  always_comb begin
    masks.kmask = byte_mask(key_bytes);
    masks.vmask = byte_mask(value_bytes);
  end

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.mode     = mode_t'(mode);
    push_item.key      = key & masks.kmask;
    push_item.value    = value & masks.vmask;
    push_item.store_en = (value_bytes != '0);
  end

endmodule

### rtl/core/mrt_queue.sv
// Short request queue between front end and table back end.
module mrt_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mrt_pkg::item_t  push_item,
  output logic            full,
  input  logic            pop,
  output mrt_pkg::item_t  head,
  output logic            empty
);
  import mrt_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/mrt_back.sv
// Back end: entry table, parallel key match, update and result register.
module mrt_back (
  input  logic                        clk,
  input  logic                        rst,
  input  mrt_pkg::masks_t             masks,
  input  mrt_pkg::item_t              head,
  input  logic                        q_empty,
  output logic                        pop,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        hit,
  output logic [mrt_pkg::DATA_W-1:0]  result,
  output logic                        result_ready,
  output logic                        table_full
);
  import mrt_pkg::*;

  logic [DATA_W-1:0]  entry_key   [ENTRIES];
  logic [DATA_W-1:0]  entry_value [ENTRIES];
  logic [ENTRIES-1:0] entry_has_value;
  logic [COUNT_W-1:0] entry_count;

  back_state_t        state;
  back_state_t        state_next;
  item_t              cur;
  logic [ENTRIES-1:0] match;
  logic [ENTRIES-1:0] match_next;

  logic               do_update;
  logic               any;
  logic [IDX_W-1:0]   old_idx;
  logic [IDX_W-1:0]   new_idx;
  logic [IDX_W-1:0]   ins_idx;
  logic               room;
  logic               do_insert;
  logic               do_store;
  logic               out_free;

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    do_update  = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          pop        = 1'b1;
          state_next = BK_MATCH;
        end
      end
      BK_MATCH: begin
        if (out_free) begin
          do_update  = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match_next[i] = (COUNT_W'(i) < entry_count) &&
                      ((entry_key[i] & masks.kmask) == head.key);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur   <= head;
      match <= match_next;
    end
  end

  always_comb begin
    any     = |match;
    old_idx = '0;
    new_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        old_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) begin
        new_idx = IDX_W'(i);
      end
    end
    ins_idx   = entry_count[IDX_W-1:0];
    room      = (entry_count < COUNT_W'(ENTRIES));
    do_insert = do_update && (cur.mode == MODE_LOOKUP) && !any && room;
    do_store  = do_update && (cur.mode == MODE_STORE) && any && cur.store_en;
  end

  always_ff @(posedge clk) begin
    if (do_insert) begin
      entry_key[ins_idx] <= cur.key;
    end
    if (do_store) begin
      entry_value[new_idx] <= cur.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count     <= '0;
      entry_has_value <= '0;
    end else begin
      if (do_insert) begin
        entry_has_value[ins_idx] <= 1'b0;
        entry_count              <= entry_count + 1'b1;
      end
      if (do_store) begin
        entry_has_value[new_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (do_update) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_update) begin
      hit          <= any;
      result       <= '0;
      result_ready <= 1'b0;
      table_full   <= 1'b0;
      if (cur.mode == MODE_LOOKUP) begin
        if (any && entry_has_value[old_idx]) begin
          result       <= entry_value[old_idx] & masks.vmask;
          result_ready <= 1'b1;
        end
        table_full <= !any && !room;
      end
    end
  end

endmodule

### rtl/core/memo_result_table.sv
// Top level of the memo result table: front end, request queue, table back end.
// An accepted request goes to a queue slot, then to cur and match, then to the result.
// One request at a time: match, then update once the output is free, then the next pop.
// The front end takes new requests while the back end works, until the queue is full.
// Reset (rst, synchronous): queue emptied, table emptied, key_bytes and value_bytes to 8.
module memo_result_table (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            mode,
  input  logic [mrt_pkg::DATA_W-1:0]      key,
  input  logic [mrt_pkg::DATA_W-1:0]      value,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            hit,
  output logic [mrt_pkg::DATA_W-1:0]      result,
  output logic                            result_ready,
  output logic                            table_full,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mrt_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mrt_pkg::*;

  logic   q_full;
  logic   q_empty;
  logic   push;
  logic   pop;
  item_t  push_item;
  item_t  head;
  masks_t masks;

  mrt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .key       (key),
    .value     (value),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .masks     (masks)
  );

  mrt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty)
  );

  mrt_back u_back (
    .clk          (clk),
    .rst          (rst),
    .masks        (masks),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .hit          (hit),
    .result       (result),
    .result_ready (result_ready),
    .table_full   (table_full)
  );

endmodule

### rtl/core/mrt_checker.sv
// Port-level checker for the memo result table, bound to the top level.
`include "memo_result_table_macros.svh"

module mrt_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic                        hit,
  input logic [mrt_pkg::DATA_W-1:0]  result,
  input logic                        result_ready,
  input logic                        table_full
);

  `MRT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "stalled result dropped")
  `MRT_ASSERT_SAME(a_full_is_miss, out_valid && table_full, !hit && !result_ready, "full on hit")
  `MRT_ASSERT_SAME(a_ready_needs_hit, out_valid && result_ready, hit && !table_full, "ready w/o hit")
  `MRT_ASSERT_SAME(a_miss_zero, out_valid && !hit, result == '0 && !result_ready, "miss not zero")

endmodule

bind memo_result_table mrt_checker u_mrt_checker (.*);

### test/memo_result_checker.sv
// Checker for the memo result table: predicts each answer and compares it with the block.
`timescale 1ns / 100ps
module memo_result_checker
  import mrt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic                  mode,
  input  logic [DATA_W-1:0]     key,
  input  logic [DATA_W-1:0]     value,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  hit,
  input  logic [DATA_W-1:0]     result,
  input  logic                  result_ready,
  input  logic                  table_full,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    pending
);

  typedef struct packed {
    logic              hit;
    logic [DATA_W-1:0] result;
    logic              ready;
    logic              full;
  } answer_t;

  logic [DATA_W-1:0]     memo_key   [ENTRIES];
  logic [DATA_W-1:0]     memo_value [ENTRIES];
  logic                  memo_filled[ENTRIES];
  int                    memo_count;
  logic [CFG_DATA_W-1:0] key_span;
  logic [CFG_DATA_W-1:0] value_span;
  answer_t               answers_due[$];
  answer_t               want;

  function automatic logic [DATA_W-1:0] span_mask(logic [CFG_DATA_W-1:0] n);
    if (n == 0) return '0;
    if (n >= 8) return '1;
    return (DATA_W'(1) << (8 * n)) - DATA_W'(1);
  endfunction

  // Lookup: oldest match wins, miss appends. Store: newest match takes the value.
  function automatic answer_t serve_request(mode_t op, logic [DATA_W-1:0] k_in,
                                            logic [DATA_W-1:0] v_in);
    answer_t           a;
    logic [DATA_W-1:0] km;
    logic [DATA_W-1:0] vm;
    logic [DATA_W-1:0] k;
    bit                found;
    a     = '0;
    km    = span_mask(key_span);
    vm    = span_mask(value_span);
    k     = k_in & km;
    found = 1'b0;
    if (op == MODE_LOOKUP) begin
      for (int i = 0; i < memo_count; i++) begin
        if (!found && (memo_key[i] & km) == k) begin
          found = 1'b1;
          a.hit = 1'b1;
          if (memo_filled[i]) begin
            a.result = memo_value[i] & vm;
            a.ready  = 1'b1;
          end
        end
      end
      if (!found) begin
        if (memo_count < ENTRIES) begin
          memo_key[memo_count]    = k;
          memo_value[memo_count]  = '0;
          memo_filled[memo_count] = 1'b0;
          memo_count++;
        end else begin
          a.full = 1'b1;
        end
      end
    end else begin
      for (int i = memo_count - 1; i >= 0; i--) begin
        if (!found && (memo_key[i] & km) == k) begin
          found = 1'b1;
          a.hit = 1'b1;
          if (value_span != 0) begin
            memo_value[i]  = v_in & vm;
            memo_filled[i] = 1'b1;
          end
        end
      end
    end
    return a;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      answers_due.delete();
      fail_count = 0;
      memo_count = 0;
      key_span   = KEY_BYTES_RESET;
      value_span = VALUE_BYTES_RESET;
      for (int i = 0; i < ENTRIES; i++) memo_filled[i] = 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_KEY_BYTES: begin
            key_span = cfg_data;
          end
          REG_VALUE_BYTES: begin
            value_span = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) answers_due.push_back(serve_request(mode_t'(mode), key, value));
      if (out_valid && !out_stall) begin
        if (answers_due.size() == 0) begin
          $error("answer with no request pending: hit %0b result %h", hit, result);
          fail_count++;
        end else begin
          want = answers_due.pop_front();
          if (hit !== want.hit) begin
            $error("hit: expected %0b, got %0b", want.hit, hit);
            fail_count++;
          end
          if (result !== want.result) begin
            $error("result: expected %h, got %h", want.result, result);
            fail_count++;
          end
          if (result_ready !== want.ready) begin
            $error("result_ready: expected %0b, got %0b", want.ready, result_ready);
            fail_count++;
          end
          if (table_full !== want.full) begin
            $error("table_full: expected %0b, got %0b", want.full, table_full);
            fail_count++;
          end
        end
      end
    end
    pending = answers_due.size();
  end

endmodule

### test/tb_memo_result_table.sv
// Testbench top for the memo result table: stimulus, config phases, watchdog and verdict.
`timescale 1ns / 100ps
module tb_memo_result_table;
  import mrt_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 228;
  localparam int DRAIN_CYCLES = 10;
  localparam int POOL_MAX     = 24;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(15);
  localparam logic [DATA_W-1:0]    ALL_ONES   = '1;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic                  mode = 1'b0;
  logic [DATA_W-1:0]     key = '0;
  logic [DATA_W-1:0]     value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  hit;
  logic [DATA_W-1:0]     result;
  logic                  result_ready;
  logic                  table_full;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    fail_count;
  int                    pending;

  bit                    calm = 1'b0;
  int                    hold_req = 0;
  int                    key_span = 8;
  logic [DATA_W-1:0]     seen_keys[$];

  logic [CFG_DATA_W-1:0] key_plan   [0:PHASES-1] = '{8, 1, 2, 0, 15, 4, 3, 9};
  logic [CFG_DATA_W-1:0] value_plan [0:PHASES-1] = '{8, 0, 8, 5, 15, 1, 2, 7};

  memo_result_table u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .result(result), .result_ready(result_ready), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  memo_result_checker u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .mode(mode), .key(key), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .hit(hit), .result(result), .result_ready(result_ready), .table_full(table_full),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  task automatic send_request(input mode_t op, input logic [DATA_W-1:0] k,
                              input logic [DATA_W-1:0] v);
    int gap;
    @(negedge clk);
    in_valid <= 1'b1;
    mode     <= op;
    key      <= k;
    value    <= v;
    do @(posedge clk); while (in_stall);
    gap = pause_len();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic ask(input logic [DATA_W-1:0] k);
    if (seen_keys.size() < POOL_MAX) seen_keys.push_back(k & ~(ALL_ONES << (8 * key_span)));
    send_request(MODE_LOOKUP, k, rand64());
  endtask

  task automatic put(input logic [DATA_W-1:0] k, input logic [DATA_W-1:0] v);
    send_request(MODE_STORE, k, v);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic set_widths(input logic [CFG_DATA_W-1:0] kb, input logic [CFG_DATA_W-1:0] vb);
    settle();
    write_reg(REG_KEY_BYTES, kb);
    write_reg(REG_VALUE_BYTES, vb);
    key_span = (kb > 8) ? 8 : int'(kb);
  endtask

  // receiver: free runs and stall runs; a hold request forces one long stall
  initial begin
    int stall_left;
    int free_left;
    int hold_seen;
    stall_left = 0;
    free_left  = 0;
    hold_seen  = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen  = hold_req;
        free_left  = 0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left == 0 && free_left == 0) begin
        free_left  = $urandom_range(1, 12);
        stall_left = pause_len();
      end
      if (free_left > 0) begin
        out_stall <= 1'b0;
        free_left--;
      end else begin
        out_stall <= 1'b1;
        stall_left--;
      end
    end
  end

  initial begin
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        idle = 0;
      else
        idle++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    logic [DATA_W-1:0] pk;
    int                r;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset widths: insert, hit before store, store, no-match store
    ask('0);
    ask(ALL_ONES);
    ask('0);
    put(ALL_ONES, ALL_ONES);
    ask(ALL_ONES);
    put('0, '0);
    put(64'h0123_4567_89AB_CDEF, rand64());
    ask('0);

    // no result width
    set_widths(8, 0);
    put(ALL_ONES, rand64());
    ask(ALL_ONES);

    // zero key width matches every entry; value width saturates
    set_widths(0, 15);
    ask(rand64());
    put(rand64(), rand64());

    // key width saturates
    set_widths(15, 3);
    ask(ALL_ONES);

    // one key byte: fill the table, then a miss that cannot be inserted
    set_widths(1, 8);
    ask(64'h55AA_55AA_0000_00AB);
    for (int i = 1; i <= 13; i++) ask((rand64() & ~64'hFF) | DATA_W'(i));
    ask(64'hC0);
    settle();
    write_reg(REG_UNUSED, CFG_DATA_W'($urandom));

    for (int ph = 0; ph < PHASES; ph++) begin
      set_widths(key_plan[ph], value_plan[ph]);
      calm = (ph == 3 || ph == 6);
      if (ph == 1) begin
        @(posedge clk);
        hold_req++;
        calm = 1'b1;
        repeat (12) put(seen_keys[$urandom_range(0, seen_keys.size() - 1)], rand64());
        calm = 1'b0;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        pk = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
        if ($urandom_range(0, 1)) pk ^= rand64() << (8 * key_span);
        r = $urandom_range(0, 99);
        if (r < 45) ask(pk);
        else if (r < 80) put(pk, rand64());
        else if (r < 90) ask(rand64());
        else put(rand64(), rand64());
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
